@@ hw/rtl/ales_pkg.sv @@
// Shared types and constants of the adjacency list edge store.
package ales_pkg;

  localparam int REQ_W      = 3;
  localparam int VERTEX_W   = 4;
  localparam int VCOUNT_W   = 5;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 7;
  localparam int LIST_COUNT = 16;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TEST   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEGREE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WR,
    ST_WALK,
    ST_UNLINK_LINK,
    ST_UNLINK_FREE,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/adjacency_list_edge_store.sv @@
// Adjacency list edge store: per-vertex linked lists in a node pool with a free list.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_ready   req_type, src_vertex, dst_vertex, directed
//   out      source     out_valid/out_ready status, found, value, last
//   cfg      sink       cfg_valid/cfg_ready vertex_count
//
// Add goes decode, add write (again when undirected), finish; rejects skip to finish.
// Remove, test, degree and list walk one node per cycle (list only while out is free)
// through the node memory, whose single registered read port sets the rate; a remove
// unlinks via ST_UNLINK_LINK/FREE; an undirected one also walks the dst list.
// Reset empties all lists at once; per-node written bits stand in for the free chain.
// A low out_ready holds the sequencer at the beat it is trying to send.
module adjacency_list_edge_store #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ales_pkg::REQ_W-1:0]      in_req_type,
  input  logic [ales_pkg::VERTEX_W-1:0]   in_src_vertex,
  input  logic [ales_pkg::VERTEX_W-1:0]   in_dst_vertex,
  input  logic                            in_directed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ales_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_found,
  output logic [ales_pkg::VALUE_W-1:0]    out_value,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ales_pkg::VCOUNT_W-1:0]   cfg_vertex_count
);
  import ales_pkg::*;

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL_LINK  = LW'(POOL_ENTRIES);
  localparam logic [LW-1:0] LAST_STEP = LW'(POOL_ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [VERTEX_W-1:0] src_r, src_nxt;
  logic [VERTEX_W-1:0] dst_r, dst_nxt;
  logic                dir_r, dir_nxt;
  logic                phase_r, phase_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       step_r, step_nxt;
  logic [VALUE_W-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]       next_link_r, next_link_nxt;
  logic [STATUS_W-1:0] fin_status_r, fin_status_nxt;
  logic                fin_found_r, fin_found_nxt;
  logic [VALUE_W-1:0]  fin_value_r, fin_value_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic [LW-1:0]       free_count_r, free_count_nxt;
  logic [VCOUNT_W-1:0] vcount_r, vcount_nxt;

  logic [LW-1:0]           list_head_r [LIST_COUNT];
  logic [POOL_ENTRIES-1:0] written_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_last_r;

  // Node memory and its registered read port.
  logic [VERTEX_W-1:0] node_vertex_mem [POOL_ENTRIES];
  logic [LW-1:0]       node_next_mem [POOL_ENTRIES];
  logic [VERTEX_W-1:0] nv_q;
  logic [LW-1:0]       nn_q;
  logic [IW-1:0]       rd_addr_q;
  logic                wr_q;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                mem_we_vtx, mem_we_next;
  logic [IW-1:0]       mem_wr_addr;
  logic [VERTEX_W-1:0] mem_wr_vtx;
  logic [LW-1:0]       mem_wr_next;
  logic                head_we;
  logic [VERTEX_W-1:0] head_wr_idx;
  logic [LW-1:0]       head_wr_val;
  logic                mark_written;

  logic                emit_en;
  logic [STATUS_W-1:0] emit_status;
  logic                emit_found;
  logic [VALUE_W-1:0]  emit_value;
  logic                emit_last;

  logic [VERTEX_W-1:0] list_idx, head_idx, target;
  logic [LW-1:0]       head_raw, nx_raw, nx_link;
  logic                head_null, nx_null, hit, at_end, can_emit;
  logic                src_ok, dst_ok, pool_short, in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  assign can_emit = !out_valid_r || out_ready;

  // The second pass of an undirected request works on the destination's list.
  assign list_idx  = phase_r ? dst_r : src_r;
  assign target    = phase_r ? src_r : dst_r;
  assign head_idx  = (state_r == ST_UNLINK_FREE) ? dst_r : list_idx;
  assign head_raw  = list_head_r[head_idx];
  assign head_null = (head_raw >= NIL_LINK);

  // A node never written is read as linking to the following entry.
  assign nx_raw  = wr_q ? nn_q : (LW'(rd_addr_q) + LW'(1));
  assign nx_null = (nx_raw >= NIL_LINK);
  assign nx_link = nx_null ? NIL_LINK : nx_raw;
  assign hit     = (nv_q == target);
  assign at_end  = nx_null || (step_r == LAST_STEP);

  assign src_ok     = ({1'b0, src_r} < vcount_r);
  assign dst_ok     = ({1'b0, dst_r} < vcount_r);
  assign pool_short = (free_count_r < (dir_r ? LW'(1) : LW'(2)));

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    dir_nxt        = dir_r;
    phase_nxt      = phase_r;
    prev_nxt       = prev_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    next_link_nxt  = next_link_r;
    fin_status_nxt = fin_status_r;
    fin_found_nxt  = fin_found_r;
    fin_value_nxt  = fin_value_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    vcount_nxt     = vcount_r;
    rd_en          = 1'b0;
    rd_addr        = free_head_r[IW-1:0];
    mem_we_vtx     = 1'b0;
    mem_we_next    = 1'b0;
    mem_wr_addr    = rd_addr_q;
    mem_wr_vtx     = target;
    mem_wr_next    = free_head_r;
    head_we        = 1'b0;
    head_wr_idx    = list_idx;
    head_wr_val    = NIL_LINK;
    mark_written   = 1'b0;
    emit_en        = 1'b0;
    emit_status    = STATUS_OK;
    emit_found     = 1'b0;
    emit_value     = '0;
    emit_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          vcount_nxt = cfg_vertex_count;
        end
        if (in_fire) begin
          req_nxt   = in_req_type;
          src_nxt   = in_src_vertex;
          dst_nxt   = in_dst_vertex;
          dir_nxt   = in_directed;
          phase_nxt = 1'b0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        fin_status_nxt = STATUS_OK;
        fin_found_nxt  = 1'b0;
        fin_value_nxt  = '0;
        prev_nxt       = NIL_LINK;
        step_nxt       = '0;
        cnt_nxt        = '0;
        if (req_r > REQ_LIST) begin
          state_nxt = ST_FINISH;
        end else if (!src_ok || (req_r <= REQ_TEST && !dst_ok)) begin
          fin_status_nxt = STATUS_RANGE;
          state_nxt      = ST_FINISH;
        end else if (req_r == REQ_ADD) begin
          if (pool_short) begin
            fin_status_nxt = STATUS_FULL;
            state_nxt      = ST_FINISH;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = free_head_r[IW-1:0];
            state_nxt = ST_ADD_WR;
          end
        end else if (head_null) begin
          if (req_r == REQ_REMOVE) begin
            fin_status_nxt = STATUS_MISS;
          end
          state_nxt = ST_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_raw[IW-1:0];
          state_nxt = ST_WALK;
        end
      end

      ST_ADD_WR: begin
        // Pop the free list head and push it on the selected list.
        mem_we_vtx     = 1'b1;
        mem_we_next    = 1'b1;
        mem_wr_addr    = rd_addr_q;
        mem_wr_vtx     = target;
        mem_wr_next    = head_raw;
        head_we        = 1'b1;
        head_wr_idx    = list_idx;
        head_wr_val    = LW'(rd_addr_q);
        mark_written   = 1'b1;
        free_head_nxt  = nx_link;
        free_count_nxt = free_count_r - LW'(1);
        if (!phase_r && !dir_r) begin
          phase_nxt = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = nx_link[IW-1:0];
        end else begin
          fin_status_nxt = STATUS_OK;
          state_nxt      = ST_FINISH;
        end
      end

      ST_WALK: begin
        case (req_r)
          REQ_TEST: begin
            if (hit || at_end) begin
              fin_found_nxt = hit;
              state_nxt     = ST_FINISH;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = nx_link[IW-1:0];
              step_nxt = step_r + LW'(1);
            end
          end
          REQ_DEGREE: begin
            cnt_nxt = cnt_r + VALUE_W'(1);
            if (at_end) begin
              fin_value_nxt = cnt_r + VALUE_W'(1);
              state_nxt     = ST_FINISH;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = nx_link[IW-1:0];
              step_nxt = step_r + LW'(1);
            end
          end
          REQ_LIST: begin
            if (can_emit) begin
              emit_en    = 1'b1;
              emit_found = 1'b1;
              emit_value = VALUE_W'(nv_q);
              emit_last  = at_end;
              if (at_end) begin
                state_nxt = ST_IDLE;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = nx_link[IW-1:0];
                step_nxt = step_r + LW'(1);
              end
            end
          end
          default: begin
            // Remove: find the first matching node, remembering its predecessor.
            if (hit) begin
              next_link_nxt = nx_link;
              state_nxt     = ST_UNLINK_LINK;
            end else if (at_end) begin
              fin_status_nxt = phase_r ? STATUS_OK : STATUS_MISS;
              state_nxt      = ST_FINISH;
            end else begin
              prev_nxt = LW'(rd_addr_q);
              rd_en    = 1'b1;
              rd_addr  = nx_link[IW-1:0];
              step_nxt = step_r + LW'(1);
            end
          end
        endcase
      end

      ST_UNLINK_LINK: begin
        if (prev_r == NIL_LINK) begin
          head_we     = 1'b1;
          head_wr_idx = list_idx;
          head_wr_val = next_link_r;
        end else begin
          mem_we_next = 1'b1;
          mem_wr_addr = prev_r[IW-1:0];
          mem_wr_next = next_link_r;
        end
        state_nxt = ST_UNLINK_FREE;
      end

      ST_UNLINK_FREE: begin
        mem_we_next    = 1'b1;
        mem_wr_addr    = rd_addr_q;
        mem_wr_next    = free_head_r;
        free_head_nxt  = LW'(rd_addr_q);
        free_count_nxt = free_count_r + LW'(1);
        fin_status_nxt = STATUS_OK;
        if (!phase_r && !dir_r && !head_null) begin
          phase_nxt = 1'b1;
          prev_nxt  = NIL_LINK;
          step_nxt  = '0;
          rd_en     = 1'b1;
          rd_addr   = head_raw[IW-1:0];
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (can_emit) begin
          emit_en     = 1'b1;
          emit_status = fin_status_r;
          emit_found  = fin_found_r;
          emit_value  = fin_value_r;
          emit_last   = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_head_r  <= '0;
      free_count_r <= LW'(POOL_ENTRIES);
      vcount_r     <= VCOUNT_RESET;
      written_r    <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        list_head_r[i] <= NIL_LINK;
      end
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      vcount_r     <= vcount_nxt;
      if (mark_written) begin
        written_r[rd_addr_q] <= 1'b1;
      end
      if (head_we) begin
        list_head_r[head_wr_idx] <= head_wr_val;
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    dir_r        <= dir_nxt;
    phase_r      <= phase_nxt;
    prev_r       <= prev_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    next_link_r  <= next_link_nxt;
    fin_status_r <= fin_status_nxt;
    fin_found_r  <= fin_found_nxt;
    fin_value_r  <= fin_value_nxt;
    if (emit_en) begin
      out_status_r <= emit_status;
      out_found_r  <= emit_found;
      out_value_r  <= emit_value;
      out_last_r   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we_vtx) begin
      node_vertex_mem[mem_wr_addr] <= mem_wr_vtx;
    end
    if (mem_we_next) begin
      node_next_mem[mem_wr_addr] <= mem_wr_next;
    end
    if (rd_en) begin
      nv_q      <= node_vertex_mem[rd_addr];
      nn_q      <= node_next_mem[rd_addr];
      wr_q      <= written_r[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= LW'(POOL_ENTRIES))
    else $error("free count exceeds the pool size");

  a_free_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (free_count_r == '0) == (free_head_r >= NIL_LINK))
    else $error("free list head disagrees with free count");

  a_add_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_WR) |=> (free_count_r == $past(free_count_r) - LW'(1)))
    else $error("add did not take exactly one free node");

  a_unlink_frees_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNLINK_FREE) |=> (free_head_r == LW'($past(rd_addr_q))))
    else $error("unlinked node is not the new free list head");

  a_out_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit_en)
    else $error("new beat loaded over a stalled one");

endmodule
